/* rtl/bfs_pkg.sv */
// Shared constants for the breadth-first search shortest-path engine.
// Used by the channel interfaces, the engine top level and the testbench; depends on nothing.
package bfs_pkg;

  localparam int DEF_MAX_VERTICES = 32;
  localparam int DEF_MAX_EDGES    = 128;
  localparam int VERTEX_LIMIT     = 32;

  localparam int VERTEX_W = 5;
  localparam int HOPS_W   = 5;
  localparam int COUNT_W  = 6;

  localparam logic [COUNT_W-1:0] VCOUNT_RESET = 6'd32;

  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_SEARCH   = 1'b1;

endpackage

/* rtl/bfs_in_if.sv */
// Input channel of the search engine: one command item per handshake.
// Depends on bfs_pkg for field widths.
interface bfs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [bfs_pkg::VERTEX_W-1:0]  first_vertex;
  logic [bfs_pkg::VERTEX_W-1:0]  second_vertex;
  logic                          both_ways;

  modport source (output valid, operation, first_vertex, second_vertex, both_ways,
                  input ready);
  modport sink (input valid, operation, first_vertex, second_vertex, both_ways,
                output ready);
endinterface

/* rtl/bfs_out_if.sv */
// Result channel of the search engine: one path vertex per item.
// Depends on bfs_pkg for field widths.
interface bfs_out_if;
  logic                          valid;
  logic                          ready;
  logic [bfs_pkg::VERTEX_W-1:0]  path_vertex;
  logic [bfs_pkg::HOPS_W-1:0]    hops;
  logic                          found;
  logic                          edges_dropped;
  logic                          last;

  modport source (output valid, path_vertex, hops, found, edges_dropped, last,
                  input ready);
  modport sink (input valid, path_vertex, hops, found, edges_dropped, last,
                output ready);
endinterface

/* rtl/bfs_cfg_if.sv */
// Configuration write channel carrying the vertex count register.
// Depends on bfs_pkg for the register width.
interface bfs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bfs_pkg::COUNT_W-1:0]  vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink (input valid, vertex_count, output ready);
endinterface

/* rtl/bfs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for every store of the search engine.
module bfs_ram #(
  parameter int W = 8,
  parameter int D = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/bfs_shortest_path_engine_unit.sv */
// Top level of the breadth-first search shortest-path engine.
// Depends on bfs_pkg, the three channel interfaces and bfs_ram.
//
// Usage: in_chan carries add-edge and search items, out_chan returns path
// items, cfg_chan writes the vertex count (always ready; write it only while
// the block is idle). An add-edge item reads the list tail and writes each
// stored append, drops an append when the edge store is full, and yields no
// result; one with an invalid vertex finishes at acceptance. A search item
// clears the visited marks, then takes each dequeued vertex through the
// dequeue, node and list states (no list state for an empty list) and scans
// its adjacency entries one at a time, as each store has one read port. It
// then returns the path from destination to source, one item per cycle while
// the receiver is ready, with last set on the source item. An invalid vertex
// or an unreachable destination gives a single item with found clear. in_chan
// is ready only while no item is in progress; one finished result sits in the
// output register, and a stalled receiver holds the path walk in place.
// Reset empties all adjacency lists, clears the edge count and the dropped
// flag, and sets the vertex count to 32; no clearing pass is needed.
module bfs_shortest_path_engine_unit #(
  parameter int MAX_VERTICES = bfs_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = bfs_pkg::DEF_MAX_EDGES
) (
  input  logic        clk,
  input  logic        rst_n,
  bfs_in_if.sink      in_chan,
  bfs_out_if.source   out_chan,
  bfs_cfg_if.sink     cfg_chan
);

  localparam int VIW  = $clog2(MAX_VERTICES);
  localparam int EW   = $clog2(MAX_EDGES);
  localparam int QW   = $clog2(MAX_VERTICES + 1);
  localparam int NLIM = (MAX_VERTICES < bfs_pkg::VERTEX_LIMIT) ?
                        MAX_VERTICES : bfs_pkg::VERTEX_LIMIT;
  localparam int VW   = bfs_pkg::VERTEX_W;
  localparam int HW   = bfs_pkg::HOPS_W;
  localparam int CW   = bfs_pkg::COUNT_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADD_RD = 4'd1;
  localparam logic [3:0] S_ADD_WR = 4'd2;
  localparam logic [3:0] S_INIT   = 4'd3;
  localparam logic [3:0] S_DEQ    = 4'd4;
  localparam logic [3:0] S_NODE   = 4'd5;
  localparam logic [3:0] S_LIST   = 4'd6;
  localparam logic [3:0] S_EDGE   = 4'd7;
  localparam logic [3:0] S_CHK    = 4'd8;
  localparam logic [3:0] S_WALK   = 4'd9;
  localparam logic [3:0] S_MISS   = 4'd10;

  logic [3:0]              state_r, state_nxt;
  logic [CW-1:0]           vcount_r;
  logic [EW:0]             total_r, total_nxt;
  logic                    dropped_r, dropped_nxt;
  logic [MAX_VERTICES-1:0] lvalid_r, lvalid_nxt;
  logic [MAX_VERTICES-1:0] seen_r, seen_nxt;
  logic [VW-1:0]           a_r, a_nxt, b_r, b_nxt;
  logic                    both_r, both_nxt, pass_r, pass_nxt;
  logic [VW-1:0]           node_r, node_nxt, cur_r, cur_nxt;
  logic [EW-1:0]           e_r, e_nxt, tail_r, tail_nxt;
  logic [HW-1:0]           nhop_r, nhop_nxt;
  logic [QW-1:0]           qhead_r, qhead_nxt, qtail_r, qtail_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [VW-1:0]           out_vertex_r, out_vertex_nxt;
  logic [HW-1:0]           out_hops_r, out_hops_nxt;
  logic                    out_found_r, out_found_nxt;
  logic                    out_dropped_r, out_dropped_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    tgt_we, next_we, head_we, ltail_we, queue_we, hop_we, came_we;
  logic [EW-1:0]           tgt_waddr, next_waddr, tgt_raddr, next_raddr;
  logic [VIW-1:0]          head_waddr, ltail_waddr, queue_waddr, hop_waddr, came_waddr;
  logic [VIW-1:0]          head_raddr, ltail_raddr, queue_raddr, hop_raddr, came_raddr;
  logic [VW-1:0]           tgt_wdata, queue_wdata, came_wdata;
  logic [EW-1:0]           next_wdata, head_wdata, ltail_wdata;
  logic [HW-1:0]           hop_wdata;
  logic [VW-1:0]           tgt_rdata, queue_rdata, came_rdata;
  logic [EW-1:0]           next_rdata, head_rdata, ltail_rdata;
  logic [HW-1:0]           hop_rdata;

  logic [CW-1:0]           n_eff;
  logic                    in_acc, out_free, out_load;
  logic                    in_bad;
  logic [VW-1:0]           from_v, to_v;
  logic [VW-1:0]           nb;
  logic                    nb_new;
  logic [EW-1:0]           slot;

  assign n_eff    = (vcount_r > CW'(NLIM)) ? CW'(NLIM) : vcount_r;
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_free = !out_valid_r || out_chan.ready;
  assign in_bad   = ({1'b0, in_chan.first_vertex} >= n_eff) ||
                    ({1'b0, in_chan.second_vertex} >= n_eff);
  assign from_v   = pass_r ? b_r : a_r;
  assign to_v     = pass_r ? a_r : b_r;
  assign slot     = total_r[EW-1:0];
  assign nb       = tgt_rdata;
  assign nb_new   = ({1'b0, nb} < n_eff) && !seen_r[VIW'(nb)];

  always_comb begin
    state_nxt       = state_r;
    total_nxt       = total_r;
    dropped_nxt     = dropped_r;
    lvalid_nxt      = lvalid_r;
    seen_nxt        = seen_r;
    a_nxt           = a_r;
    b_nxt           = b_r;
    both_nxt        = both_r;
    pass_nxt        = pass_r;
    node_nxt        = node_r;
    cur_nxt         = cur_r;
    e_nxt           = e_r;
    tail_nxt        = tail_r;
    nhop_nxt        = nhop_r;
    qhead_nxt       = qhead_r;
    qtail_nxt       = qtail_r;
    out_load        = 1'b0;
    out_vertex_nxt  = out_vertex_r;
    out_hops_nxt    = out_hops_r;
    out_found_nxt   = out_found_r;
    out_dropped_nxt = out_dropped_r;
    out_last_nxt    = out_last_r;
    tgt_we = 1'b0;  tgt_waddr = slot;  tgt_wdata = to_v;
    next_we = 1'b0; next_waddr = ltail_rdata; next_wdata = slot;
    head_we = 1'b0; head_waddr = VIW'(from_v); head_wdata = slot;
    ltail_we = 1'b0; ltail_waddr = VIW'(from_v); ltail_wdata = slot;
    queue_we = 1'b0; queue_waddr = qtail_r[VIW-1:0]; queue_wdata = nb;
    hop_we = 1'b0;  hop_waddr = VIW'(nb); hop_wdata = nhop_r;
    came_we = 1'b0; came_waddr = VIW'(nb); came_wdata = node_r;
    tgt_raddr = e_r;
    next_raddr = e_r;
    head_raddr = VIW'(node_r);
    ltail_raddr = VIW'(from_v);
    queue_raddr = qhead_r[VIW-1:0];
    hop_raddr = VIW'(cur_r);
    came_raddr = VIW'(cur_r);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          a_nxt    = in_chan.first_vertex;
          b_nxt    = in_chan.second_vertex;
          both_nxt = in_chan.both_ways;
          pass_nxt = 1'b0;
          if (in_chan.operation == bfs_pkg::OP_ADD_EDGE) begin
            if (in_bad) begin
              dropped_nxt = 1'b1;
            end else begin
              state_nxt = S_ADD_RD;
            end
          end else begin
            state_nxt = in_bad ? S_MISS : S_INIT;
          end
        end
      end
      S_ADD_RD: begin
        if (total_r >= (EW+1)'(MAX_EDGES)) begin
          dropped_nxt = 1'b1;
          if (both_r && !pass_r) begin
            pass_nxt = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        tgt_we   = 1'b1;
        ltail_we = 1'b1;
        if (lvalid_r[VIW'(from_v)]) begin
          next_we = 1'b1;
        end else begin
          head_we = 1'b1;
        end
        lvalid_nxt[VIW'(from_v)] = 1'b1;
        total_nxt = total_r + 1'b1;
        if (both_r && !pass_r) begin
          pass_nxt  = 1'b1;
          state_nxt = S_ADD_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_INIT: begin
        seen_nxt           = '0;
        seen_nxt[VIW'(a_r)] = 1'b1;
        queue_we    = 1'b1;
        queue_waddr = '0;
        queue_wdata = a_r;
        hop_we      = 1'b1;
        hop_waddr   = VIW'(a_r);
        hop_wdata   = '0;
        qhead_nxt   = '0;
        qtail_nxt   = QW'(1);
        state_nxt   = S_DEQ;
      end
      S_DEQ: begin
        if (qhead_r == qtail_r) begin
          state_nxt = S_CHK;
        end else begin
          qhead_nxt = qhead_r + 1'b1;
          state_nxt = S_NODE;
        end
      end
      S_NODE: begin
        node_nxt    = queue_rdata;
        head_raddr  = VIW'(queue_rdata);
        ltail_raddr = VIW'(queue_rdata);
        hop_raddr   = VIW'(queue_rdata);
        state_nxt   = lvalid_r[VIW'(queue_rdata)] ? S_LIST : S_DEQ;
      end
      S_LIST: begin
        e_nxt      = head_rdata;
        tail_nxt   = ltail_rdata;
        nhop_nxt   = hop_rdata + 1'b1;
        tgt_raddr  = head_rdata;
        next_raddr = head_rdata;
        state_nxt  = S_EDGE;
      end
      S_EDGE: begin
        if (nb_new) begin
          seen_nxt[VIW'(nb)] = 1'b1;
          came_we   = 1'b1;
          hop_we    = 1'b1;
          queue_we  = 1'b1;
          qtail_nxt = qtail_r + 1'b1;
        end
        if (e_r == tail_r) begin
          state_nxt = S_DEQ;
        end else begin
          e_nxt      = next_rdata;
          tgt_raddr  = next_rdata;
          next_raddr = next_rdata;
        end
      end
      S_CHK: begin
        if (!seen_r[VIW'(b_r)]) begin
          state_nxt = S_MISS;
        end else begin
          cur_nxt    = b_r;
          hop_raddr  = VIW'(b_r);
          came_raddr = VIW'(b_r);
          state_nxt  = S_WALK;
        end
      end
      S_WALK: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_vertex_nxt  = cur_r;
          out_hops_nxt    = hop_rdata;
          out_found_nxt   = 1'b1;
          out_dropped_nxt = dropped_r;
          out_last_nxt    = (cur_r == a_r);
          if (cur_r == a_r) begin
            state_nxt = S_IDLE;
          end else begin
            cur_nxt    = came_rdata;
            hop_raddr  = VIW'(came_rdata);
            came_raddr = VIW'(came_rdata);
          end
        end
      end
      S_MISS: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_vertex_nxt  = b_r;
          out_hops_nxt    = '0;
          out_found_nxt   = 1'b0;
          out_dropped_nxt = dropped_r;
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= bfs_pkg::VCOUNT_RESET;
      total_r     <= '0;
      dropped_r   <= 1'b0;
      lvalid_r    <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      pass_r      <= 1'b0;
      qhead_r     <= '0;
      qtail_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      dropped_r   <= dropped_nxt;
      lvalid_r    <= lvalid_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      pass_r      <= pass_nxt;
      qhead_r     <= qhead_nxt;
      qtail_r     <= qtail_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        vcount_r <= cfg_chan.vertex_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r           <= a_nxt;
    b_r           <= b_nxt;
    both_r        <= both_nxt;
    node_r        <= node_nxt;
    cur_r         <= cur_nxt;
    e_r           <= e_nxt;
    tail_r        <= tail_nxt;
    nhop_r        <= nhop_nxt;
    out_vertex_r  <= out_vertex_nxt;
    out_hops_r    <= out_hops_nxt;
    out_found_r   <= out_found_nxt;
    out_dropped_r <= out_dropped_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.path_vertex   = out_vertex_r;
  assign out_chan.hops          = out_hops_r;
  assign out_chan.found         = out_found_r;
  assign out_chan.edges_dropped = out_dropped_r;
  assign out_chan.last          = out_last_r;

  bfs_ram #(.W(VW), .D(MAX_EDGES)) u_tgt (
    .clk(clk), .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_wdata),
    .raddr(tgt_raddr), .rdata(tgt_rdata)
  );

  bfs_ram #(.W(EW), .D(MAX_EDGES)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(next_raddr), .rdata(next_rdata)
  );

  bfs_ram #(.W(EW), .D(MAX_VERTICES)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata)
  );

  bfs_ram #(.W(EW), .D(MAX_VERTICES)) u_ltail (
    .clk(clk), .we(ltail_we), .waddr(ltail_waddr), .wdata(ltail_wdata),
    .raddr(ltail_raddr), .rdata(ltail_rdata)
  );

  bfs_ram #(.W(VW), .D(MAX_VERTICES)) u_queue (
    .clk(clk), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
    .raddr(queue_raddr), .rdata(queue_rdata)
  );

  bfs_ram #(.W(HW), .D(MAX_VERTICES)) u_hop (
    .clk(clk), .we(hop_we), .waddr(hop_waddr), .wdata(hop_wdata),
    .raddr(hop_raddr), .rdata(hop_rdata)
  );

  bfs_ram #(.W(VW), .D(MAX_VERTICES)) u_came (
    .clk(clk), .we(came_we), .waddr(came_waddr), .wdata(came_wdata),
    .raddr(came_raddr), .rdata(came_rdata)
  );

  // The edge count never passes the edge store depth.
  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= (EW+1)'(MAX_EDGES))
    else $error("edge count exceeds capacity");

  // While scanning a list, the current entry was appended earlier.
  a_edge_written: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EDGE |-> (EW+1)'(e_r) < total_r)
    else $error("scan reached an unwritten edge entry");

  // The queue never holds more vertices than the vertex limit NLIM.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEQ || state_r == S_EDGE) |-> qtail_r <= QW'(NLIM))
    else $error("frontier queue overflow");

  // The final item of a search returns the block to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && out_last_nxt |=> state_r == S_IDLE)
    else $error("block busy after final item");

  // New items are taken only while no search or append is in progress.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> $past(state_nxt) == S_IDLE || state_r == S_IDLE)
    else $error("item accepted while busy");

endmodule

/* verif/tb_bfs_shortest_path_engine_unit.sv */
// Testbench for the breadth-first search shortest-path engine: drives add-edge and
// search items, predicts each path with its own graph model, and checks every result.
// Depends on bfs_pkg, the three channel interfaces and the engine top level.
class path_scoreboard;
  typedef struct packed {
    logic [4:0] path_vertex;
    logic [4:0] hops;
    logic       found;
    logic       edges_dropped;
    logic       last;
  } path_item_t;

  int unsigned vcount;
  logic [4:0] edge_to[128];
  int unsigned edge_link[128];
  int unsigned head[32];
  int unsigned tail[32];
  bit has_list[32];
  int unsigned edge_cnt;
  bit dropped;
  path_item_t pending[$];
  int unsigned mismatches;
  int unsigned searches;
  int unsigned results_seen;

  function new();
    vcount = 32;
    edge_cnt = 0;
    dropped = 0;
    mismatches = 0;
    searches = 0;
    results_seen = 0;
    foreach (has_list[i]) has_list[i] = 0;
  endfunction

  function int unsigned live_count();
    return (vcount > 32) ? 32 : vcount;
  endfunction

  function void set_count(logic [5:0] v);
    vcount = {26'd0, v};
  endfunction

  function void link_edge(int unsigned a, int unsigned b);
    if (edge_cnt >= 128) begin
      dropped = 1;
      return;
    end
    edge_to[edge_cnt] = 5'(b);
    edge_link[edge_cnt] = 0;
    if (has_list[a]) edge_link[tail[a]] = edge_cnt;
    else head[a] = edge_cnt;
    tail[a] = edge_cnt;
    has_list[a] = 1;
    edge_cnt++;
  endfunction

  function void add_expected(int unsigned v, int unsigned h, bit f, bit l);
    path_item_t r;
    r.path_vertex = 5'(v);
    r.hops = 5'(h);
    r.found = f;
    r.edges_dropped = dropped;
    r.last = l;
    pending = {pending, r};
  endfunction

  function void note_input(logic op, logic [4:0] a, logic [4:0] b, logic both);
    int unsigned n, qh, qt, node, e, nb, cur, k, ia, ib;
    bit seen[32];
    int unsigned parent[32];
    int unsigned hop_cnt[32];
    int unsigned fifo[32];
    n = live_count();
    ia = {27'd0, a};
    ib = {27'd0, b};
    if (op == bfs_pkg::OP_ADD_EDGE) begin
      if (ia >= n || ib >= n) dropped = 1;
      else begin
        link_edge(ia, ib);
        if (both) link_edge(ib, ia);
      end
      return;
    end
    searches++;
    if (ia >= n || ib >= n) begin
      add_expected(ib, 0, 0, 1);
      return;
    end
    for (int i = 0; i < 32; i++) begin
      seen[i] = 0;
      parent[i] = 63;
      hop_cnt[i] = 0;
    end
    qh = 0;
    qt = 0;
    seen[ia] = 1;
    fifo[qt++] = ia;
    while (qh < qt) begin
      node = fifo[qh++];
      if (has_list[node]) begin
        e = head[node];
        for (int s = 0; s < 128; s++) begin
          nb = {27'd0, edge_to[e]};
          if (nb < n && !seen[nb] && qt < 32) begin
            seen[nb] = 1;
            parent[nb] = node;
            hop_cnt[nb] = (hop_cnt[node] + 1) & 31;
            fifo[qt++] = nb;
          end
          if (e == tail[node]) break;
          e = edge_link[e];
          if (e >= 128) break;
        end
      end
    end
    if (!seen[ib]) begin
      add_expected(ib, 0, 0, 1);
      return;
    end
    cur = ib;
    k = 0;
    while (k < 32) begin
      add_expected(cur, hop_cnt[cur], 1, parent[cur] == 63);
      k++;
      if (parent[cur] == 63) break;
      cur = parent[cur];
    end
  endfunction

  function void check_result(path_item_t got);
    path_item_t want;
    results_seen++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result item %p", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

module tb_bfs_shortest_path_engine_unit;

  logic clk;
  logic rst_n;
  bfs_in_if in_chan();
  bfs_out_if out_chan();
  bfs_cfg_if cfg_chan();

  path_scoreboard board;
  longint unsigned cycles;
  bit stall_free;

  bfs_shortest_path_engine_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_chan(in_chan.sink), .out_chan(out_chan.source), .cfg_chan(cfg_chan.sink)
  );

  initial clk = 0;
  always #1 clk = ~clk;

  initial begin
    rst_n = 0;
    in_chan.valid = 0;
    in_chan.operation = bfs_pkg::OP_ADD_EDGE;
    in_chan.first_vertex = 0;
    in_chan.second_vertex = 0;
    in_chan.both_ways = 0;
    cfg_chan.valid = 0;
    cfg_chan.vertex_count = bfs_pkg::VCOUNT_RESET;
    out_chan.ready = 0;
    board = new();
    cycles = 0;
    stall_free = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stall before each item, with stall-free stretches.
  initial begin
    int unsigned w;
    @(posedge clk iff rst_n);
    forever begin
      w = stall_free ? 0 : $urandom_range(0, 11);
      if (w != 0) begin
        out_chan.ready <= 0;
        repeat (w) @(posedge clk);
      end
      out_chan.ready <= 1;
      @(posedge clk iff out_chan.valid);
      board.check_result({out_chan.path_vertex, out_chan.hops, out_chan.found,
                          out_chan.edges_dropped, out_chan.last});
    end
  end

  task automatic send_item(logic op, logic [4:0] a, logic [4:0] b, logic both, bit gaps);
    int unsigned w;
    w = gaps ? $urandom_range(0, 11) : 0;
    if (w != 0) begin
      in_chan.valid <= 0;
      repeat (w) @(posedge clk);
    end
    in_chan.valid <= 1;
    in_chan.operation <= op;
    in_chan.first_vertex <= a;
    in_chan.second_vertex <= b;
    in_chan.both_ways <= both;
    @(posedge clk iff in_chan.ready);
    board.note_input(op, a, b, both);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(logic [5:0] v);
    wait_drained();
    cfg_chan.valid <= 1;
    cfg_chan.vertex_count <= v;
    @(posedge clk iff cfg_chan.ready);
    board.set_count(v);
    cfg_chan.valid <= 0;
  endtask

  task automatic random_phase(int unsigned count, int unsigned span);
    int unsigned a, b;
    for (int i = 0; i < count; i++) begin
      a = $urandom_range(0, span - 1);
      b = $urandom_range(0, span - 1);
      if ($urandom_range(0, 19) == 0) begin
        a = $urandom_range(0, 31);
        b = $urandom_range(0, 31);
      end
      send_item($urandom_range(0, 99) < 60 ? bfs_pkg::OP_ADD_EDGE : bfs_pkg::OP_SEARCH,
                5'(a), 5'(b), 1'($urandom_range(0, 1)), 1);
      if (i % 40 == 39) stall_free = ~stall_free;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: chain, self loop, same endpoints, unreachable, invalid vertices.
    send_item(bfs_pkg::OP_SEARCH, 0, 0, 0, 0);
    send_item(bfs_pkg::OP_SEARCH, 0, 31, 0, 0);
    send_item(bfs_pkg::OP_ADD_EDGE, 0, 1, 1, 0);
    send_item(bfs_pkg::OP_ADD_EDGE, 1, 2, 0, 0);
    send_item(bfs_pkg::OP_ADD_EDGE, 2, 31, 1, 0);
    send_item(bfs_pkg::OP_ADD_EDGE, 5, 5, 1, 0);
    send_item(bfs_pkg::OP_ADD_EDGE, 0, 3, 0, 0);
    send_item(bfs_pkg::OP_ADD_EDGE, 3, 31, 0, 0);
    send_item(bfs_pkg::OP_SEARCH, 0, 31, 1, 1);
    send_item(bfs_pkg::OP_SEARCH, 31, 0, 0, 1);
    send_item(bfs_pkg::OP_SEARCH, 5, 5, 0, 1);
    send_item(bfs_pkg::OP_SEARCH, 2, 3, 0, 1);
    send_item(bfs_pkg::OP_SEARCH, 3, 0, 0, 1);

    write_count(6'd1);
    send_item(bfs_pkg::OP_SEARCH, 0, 0, 0, 0);
    send_item(bfs_pkg::OP_SEARCH, 0, 1, 0, 0);
    send_item(bfs_pkg::OP_ADD_EDGE, 0, 1, 0, 0);
    send_item(bfs_pkg::OP_SEARCH, 31, 31, 0, 0);
    write_count(6'd4);
    send_item(bfs_pkg::OP_SEARCH, 0, 3, 0, 0);
    write_count(6'd63);
    send_item(bfs_pkg::OP_SEARCH, 0, 31, 0, 0);
    wait_drained();

    // Random: small graphs, the full vertex range, then 16 and zero vertices as the store fills, then searches only.
    write_count(6'd8);
    random_phase(60, 8);
    write_count(6'd32);
    random_phase(70, 32);
    wait_drained();
    write_count(6'd16);
    random_phase(50, 16);
    write_count(6'd0);
    random_phase(10, 4);
    write_count(6'd32);
    for (int i = 0; i < 40; i++)
      send_item(bfs_pkg::OP_SEARCH, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                0, 1);

    stall_free = 0;
    wait_drained();
    repeat (200) @(posedge clk);
    $display("Covered %0d searches with %0d path items checked, %0d edges stored.",
             board.searches, board.results_seen, board.edge_cnt);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/bfs_pkg.sv
rtl/bfs_in_if.sv
rtl/bfs_out_if.sv
rtl/bfs_cfg_if.sv
rtl/bfs_ram.sv
rtl/bfs_shortest_path_engine_unit.sv
verif/tb_bfs_shortest_path_engine_unit.sv
